// ----- hdl/caustic_light_pixel_modulator_defines.svh -----
// assertion macros shared by the caustic light pixel modulator sources
// no dependencies; included by the files that carry concurrent checks
`ifndef CAUSTIC_LIGHT_PIXEL_MODULATOR_DEFINES_SVH
`define CAUSTIC_LIGHT_PIXEL_MODULATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CLPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CLPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/clpm_pkg.sv -----
// shared types, constants and profile table builders for the caustic light modulator
// no dependencies; imported by the lane, merge and top level modules
package clpm_pkg;

   localparam int PROFILE_DEPTH_DEF = 512;
   localparam int POOL_SPAN_DEF     = 8;
   localparam int PIPE_STAGES       = 5;
   localparam int CSR_ADDR_W        = 4;

   localparam logic [8:0]  BASE_GAIN_RST = 9'd256;
   localparam logic [8:0]  AMP_SCALE_RST = 9'd256;
   localparam logic [30:0] POOL_STEP_RST = 31'd69424;
   localparam logic [4:0]  POOL_DEPTH_K  = 5'd30;

   localparam logic [63:0]        QONE        = 64'd1073741824;
   localparam logic signed [63:0] QONE_S      = 64'sd1073741824;
   localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
   localparam logic [31:0]        OFS_B       = 32'd751921801;
   localparam logic [31:0]        OFS_D       = 32'd1640556661;

   // per-stage load strobes handed from the top level to lanes and merge
   typedef struct packed {
      logic row_load;
      logic pair_take;
      logic load_q;
      logic load_rom;
      logic load_mix;
      logic load_out;
   } pipe_ctl_type;

   // q30 sine of an angle given in 2^-32 turns
   function automatic logic signed [63:0] sin_q30(input logic [31:0] t);
      logic [63:0] f;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] s;
      f = {34'd0, t[29:0]};
      if (t[30]) begin
         f = QONE - f;
      end
      x    = (f * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = QONE - (((x2 * QONE) >> 30) / 64'd110);
      term = QONE - (((x2 * term) >> 30) / 64'd72);
      term = QONE - (((x2 * term) >> 30) / 64'd42);
      term = QONE - (((x2 * term) >> 30) / 64'd20);
      term = QONE - (((x2 * term) >> 30) / 64'd6);
      s    = (x * term) >> 30;
      if (t[31]) begin
         return -$signed(s);
      end
      return $signed(s);
   endfunction

   function automatic logic [63:0] qpow(input logic [63:0] x, input int n);
      logic [63:0] r;
      r = QONE;
      for (int i = 0; i < n; i++) begin
         r = (r * x) >> 30;
      end
      return r;
   endfunction

   // bright peaks narrow, dark troughs shallow
   function automatic logic [7:0] sharpen(input logic signed [63:0] v);
      logic [63:0] rhs;
      logic        found;
      int          kk;
      logic [7:0]  res;
      found = 1'b0;
      kk    = 0;
      if (v == 64'sd0) begin
         res = 8'd128;
      end else if (v > 64'sd0) begin
         rhs = qpow(64'(v), 11);
         for (int k = 127; k > 0; k--) begin
            if (!found) begin
               if (qpow((64'(k) << 30) / 64'd127, 5) <= rhs) begin
                  found = 1'b1;
                  kk    = k;
               end
            end
         end
         res = 8'(128 + kk);
      end else begin
         rhs = qpow(64'(-v), 8);
         for (int k = 60; k > 0; k--) begin
            if (!found) begin
               if (qpow((64'(k * 20) << 30) / 64'd889, 5) <= rhs) begin
                  found = 1'b1;
                  kk    = k;
               end
            end
         end
         res = 8'(128 - kk);
      end
      return res;
   endfunction

   function automatic logic [7:0] caustic_entry(input logic [31:0] t1,
                                                input logic [31:0] t2,
                                                input logic [31:0] t3);
      logic signed [63:0] v;
      v = (64'sd60 * sin_q30(t1) + 64'sd30 * sin_q30(t2) + 64'sd18 * sin_q30(t3))
          / 64'sd100;
      return sharpen(v);
   endfunction

   function automatic logic [7:0] pool_entry(input logic [31:0] t1);
      logic signed [63:0] p;
      p = 64'sd128 + (sin_q30(t1) * 64'sd126) / QONE_S;
      return p[7:0];
   endfunction

endpackage

// ----- hdl/caustic_light_pixel_modulator.sv -----
// top level of the caustic light pixel modulator: csr block, pipeline control, lanes
// depends on clpm_pkg, clpm_lane, clpm_merge and the shared assertion macros
//
//   channel | direction | handshake           | carries
//   req     | in        | req_valid/req_stall | row start setup or one pixel pair
//   rsp     | out       | rsp_valid/rsp_stall | two shaded pixels and their gain
//   csr     | in/out    | apb psel/penable    | base_gain, amp_scale, pool_step
//
// one transaction per cycle while req_stall is low; a pair's result passes through
// the lookup pipeline (accumulator capture, index quotient, remainder and table read) and the merge
// a row start is accepted like a pair but gives no result
// synchronous reset clears the accumulators, row depth and stage valids and loads the csr defaults
// stalls ripple back stage by stage, empty stages keep accepting behind a stalled result
`include "caustic_light_pixel_modulator_defines.svh"

module caustic_light_pixel_modulator import clpm_pkg::*; #(
   parameter int PROFILE_DEPTH = PROFILE_DEPTH_DEF,
   parameter int POOL_SPAN     = POOL_SPAN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [15:0]           req_pixel_0,
   input  logic [15:0]           req_pixel_1,
   input  logic signed [31:0]    req_phase_a,
   input  logic signed [31:0]    req_phase_b,
   input  logic signed [31:0]    req_phase_d,
   input  logic signed [31:0]    req_step_a,
   input  logic signed [31:0]    req_step_b,
   input  logic signed [31:0]    req_step_d,
   input  logic signed [31:0]    req_pool_phase,
   input  logic [7:0]            req_row_amplitude,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_lit_pixel_0,
   output logic [15:0]           rsp_lit_pixel_1,
   output logic [8:0]            rsp_light_gain,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int DEPTH_X10 = 10 * PROFILE_DEPTH;

   typedef logic [PROFILE_DEPTH-1:0][7:0] rom_type;

   typedef enum logic [1:0] {
      REG_BASE_GAIN = 2'd0,
      REG_AMP_SCALE = 2'd1,
      REG_POOL_STEP = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [15:0] pixel_0;
      logic [15:0] pixel_1;
      logic [8:0]  row_depth;
   } side_type;

   function automatic rom_type build_caustic_rom();
      rom_type     rom;
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      for (int i = 0; i < PROFILE_DEPTH; i++) begin
         t1 = 32'((64'(i) << 32) / PROFILE_DEPTH);
         t2 = 32'((64'(23 * i) << 32) / DEPTH_X10) + OFS_B;
         t3 = 32'((64'(37 * i) << 32) / DEPTH_X10) + OFS_D;
         rom[i] = caustic_entry(t1, t2, t3);
      end
      return rom;
   endfunction

   function automatic rom_type build_pool_rom();
      rom_type rom;
      for (int i = 0; i < PROFILE_DEPTH; i++) begin
         rom[i] = pool_entry(32'((64'(i) << 32) / PROFILE_DEPTH));
      end
      return rom;
   endfunction

   localparam rom_type CAUSTIC_ROM = build_caustic_rom();
   localparam rom_type POOL_ROM    = build_pool_rom();

   // csr block
   logic [8:0]    base_gain_ff, base_gain_in;
   logic [8:0]    amp_scale_ff, amp_scale_in;
   logic [30:0]   pool_step_ff, pool_step_in;
   logic          csr_write;
   reg_index_type reg_sel;

   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      base_gain_in = base_gain_ff;
      amp_scale_in = amp_scale_ff;
      pool_step_in = pool_step_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_BASE_GAIN: base_gain_in = csr_pwdata[8:0];
            REG_AMP_SCALE: amp_scale_in = csr_pwdata[8:0];
            REG_POOL_STEP: pool_step_in = csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BASE_GAIN: csr_prdata = {23'd0, base_gain_ff};
         REG_AMP_SCALE: csr_prdata = {23'd0, amp_scale_ff};
         REG_POOL_STEP: csr_prdata = {1'b0, pool_step_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_gain_ff <= BASE_GAIN_RST;
         amp_scale_ff <= AMP_SCALE_RST;
         pool_step_ff <= POOL_STEP_RST;
      end else begin
         base_gain_ff <= base_gain_in;
         amp_scale_ff <= amp_scale_in;
         pool_step_ff <= pool_step_in;
      end
   end

   // pipeline control
   logic [PIPE_STAGES-1:0] valid_ff, valid_in, stage_rdy;
   logic                   req_take;
   pipe_ctl_type           ctl;

   always_comb begin
      stage_rdy[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
   end

   assign req_stall     = !stage_rdy[0];
   assign req_take      = req_valid && !req_stall;
   assign ctl.row_load  = req_take && !req_kind;
   assign ctl.pair_take = req_take && req_kind;
   assign ctl.load_q    = stage_rdy[1];
   assign ctl.load_rom  = stage_rdy[2];
   assign ctl.load_mix  = stage_rdy[3];
   assign ctl.load_out  = stage_rdy[4];

   always_comb begin
      valid_in[0] = stage_rdy[0] ? ctl.pair_take : valid_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         valid_in[k] = stage_rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   // row depth, latched per row and carried with each pair
   logic [8:0]  row_depth_ff, row_depth_in;
   logic [16:0] depth_prod;
   side_type    side_ff [3];

   assign depth_prod   = 17'(req_row_amplitude) * 17'(amp_scale_ff);
   assign row_depth_in = ctl.row_load ? depth_prod[16:8] : row_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_depth_ff <= '0;
      end else begin
         row_depth_ff <= row_depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pair_take) begin
         side_ff[0] <= '{pixel_0: req_pixel_0, pixel_1: req_pixel_1,
                         row_depth: row_depth_ff};
      end
      if (ctl.load_q) begin
         side_ff[1] <= side_ff[0];
      end
      if (ctl.load_rom) begin
         side_ff[2] <= side_ff[1];
      end
   end

   // lanes
   logic [31:0] wave_phase [3];
   logic [31:0] wave_step  [3];
   logic [7:0]  wave_prof  [3];
   logic [7:0]  pool_prof;

   assign wave_phase[0] = req_phase_a;
   assign wave_phase[1] = req_phase_b;
   assign wave_phase[2] = req_phase_d;
   assign wave_step[0]  = req_step_a;
   assign wave_step[1]  = req_step_b;
   assign wave_step[2]  = req_step_d;

   for (genvar w = 0; w < 3; w++) begin : g_wave_lane
      clpm_lane #(
         .PROFILE_DEPTH (PROFILE_DEPTH),
         .POOL_SPAN     (POOL_SPAN),
         .IS_POOL       (1'b0),
         .TABLE         (CAUSTIC_ROM)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .load_phase (wave_phase[w]),
         .step_value (wave_step[w]),
         .prof_byte  (wave_prof[w])
      );
   end

   clpm_lane #(
      .PROFILE_DEPTH (PROFILE_DEPTH),
      .POOL_SPAN     (POOL_SPAN),
      .IS_POOL       (1'b1),
      .TABLE         (POOL_ROM)
   ) u_pool_lane (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .load_phase (req_pool_phase),
      .step_value ({1'b0, pool_step_ff}),
      .prof_byte  (pool_prof)
   );

   clpm_merge u_merge (
      .clock       (clock),
      .ctl         (ctl),
      .prof_a      (wave_prof[0]),
      .prof_b      (wave_prof[1]),
      .prof_d      (wave_prof[2]),
      .prof_pool   (pool_prof),
      .row_depth   (side_ff[2].row_depth),
      .pixel_0     (side_ff[2].pixel_0),
      .pixel_1     (side_ff[2].pixel_1),
      .base_gain   (base_gain_ff),
      .lit_pixel_0 (rsp_lit_pixel_0),
      .lit_pixel_1 (rsp_lit_pixel_1),
      .light_gain  (rsp_light_gain)
   );

   `CLPM_ASSERT_SAME(a_gain_range, clock, reset, rsp_valid, rsp_light_gain <= 9'd256,
      "light gain above unity")
   `CLPM_ASSERT_NEXT(a_row_no_result, clock, reset, ctl.row_load, !valid_ff[0],
      "row start entered the result pipeline")
   `CLPM_ASSERT_NEXT(a_pair_enters, clock, reset, ctl.pair_take, valid_ff[0],
      "accepted pair missing from first stage")
   `CLPM_ASSERT_SAME(a_full_stall, clock, reset, (&valid_ff) && rsp_stall, req_stall,
      "full pipeline accepted a transaction")

endmodule

// ----- hdl/clpm_lane.sv -----
// one profile lane: phase accumulator plus pipelined table index and profile lookup
// depends on clpm_pkg; wave lanes and the pool lane differ only in their table and in how they advance
module clpm_lane import clpm_pkg::*; #(
   parameter int PROFILE_DEPTH = PROFILE_DEPTH_DEF,
   parameter int POOL_SPAN     = POOL_SPAN_DEF,
   parameter bit IS_POOL       = 1'b0,
   parameter logic [PROFILE_DEPTH-1:0][7:0] TABLE = '0
) (
   input  logic         clock,
   input  logic         reset,
   input  pipe_ctl_type ctl,
   input  logic [31:0]  load_phase,
   input  logic [31:0]  step_value,
   output logic [7:0]   prof_byte
);

   localparam int IDX_W   = $clog2(PROFILE_DEPTH);
   localparam int RECIP_W = 33 - $clog2(PROFILE_DEPTH);
   localparam int PROD_W  = 16 + RECIP_W;
   localparam int Q_W     = PROD_W - 32;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 32) / PROFILE_DEPTH);

   logic [31:0]       acc_ff, acc_in;
   logic [15:0]       hi_ff, hi2_ff;
   logic [Q_W-1:0]    q_ff;
   logic [PROD_W-1:0] qprod;
   logic [15:0]       qd, rem, rem_fix;
   logic [7:0]        prof_ff;

   if (IS_POOL) begin : g_pool
      localparam int SPAN_W = $clog2(POOL_SPAN);
      localparam int SUM_W  = $clog2(POOL_SPAN + 2);
      logic [SPAN_W-1:0] span_ff, span_in;
      logic [SUM_W-1:0]  span_sum;

      always_comb begin
         acc_in   = acc_ff;
         span_in  = span_ff;
         span_sum = SUM_W'(span_ff) + SUM_W'(2);
         if (ctl.row_load) begin
            acc_in  = load_phase;
            span_in = '0;
         end else if (ctl.pair_take) begin
            // the pool phase moves once per span, by the whole span's worth
            if (span_sum >= SUM_W'(POOL_SPAN)) begin
               span_in = SPAN_W'(span_sum - SUM_W'(POOL_SPAN));
               acc_in  = acc_ff + 32'(step_value * 32'(POOL_SPAN));
            end else begin
               span_in = SPAN_W'(span_sum);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            span_ff <= '0;
         end else begin
            span_ff <= span_in;
         end
      end
   end else begin : g_wave
      logic [31:0] step_ff, step_in;

      always_comb begin
         acc_in  = acc_ff;
         step_in = step_ff;
         if (ctl.row_load) begin
            acc_in  = load_phase;
            step_in = step_value;
         end else if (ctl.pair_take) begin
            acc_in = acc_ff + {step_ff[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            step_ff <= '0;
         end else begin
            step_ff <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // integer part modulo the table depth: reciprocal quotient, then one correction
   assign qprod   = PROD_W'(hi_ff) * PROD_W'(RECIP);
   assign qd      = 16'(q_ff * 16'(PROFILE_DEPTH));
   assign rem     = hi2_ff - qd;
   assign rem_fix = (rem >= 16'(PROFILE_DEPTH)) ? rem - 16'(PROFILE_DEPTH) : rem;

   always_ff @(posedge clock) begin
      if (ctl.pair_take) begin
         hi_ff <= acc_ff[31:16];
      end
      if (ctl.load_q) begin
         hi2_ff <= hi_ff;
         q_ff   <= qprod[PROD_W-1:32];
      end
      if (ctl.load_rom) begin
         prof_ff <= TABLE[rem_fix[IDX_W-1:0]];
      end
   end

   assign prof_byte = prof_ff;

endmodule

// ----- hdl/clpm_merge.sv -----
// merge stage: combines the lane profiles into one gain and shades both pixels
// depends on clpm_pkg for the stage strobes and the pool depth constant
module clpm_merge import clpm_pkg::*; (
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  logic [7:0]   prof_a,
   input  logic [7:0]   prof_b,
   input  logic [7:0]   prof_d,
   input  logic [7:0]   prof_pool,
   input  logic [8:0]   row_depth,
   input  logic [15:0]  pixel_0,
   input  logic [15:0]  pixel_1,
   input  logic [8:0]   base_gain,
   output logic [15:0]  lit_pixel_0,
   output logic [15:0]  lit_pixel_1,
   output logic [8:0]   light_gain
);

   function automatic logic [15:0] scale_pixel(input logic [15:0] pix,
                                               input logic [8:0]  gain);
      logic [13:0] r_p;
      logic [14:0] g_p;
      logic [13:0] b_p;
      r_p = 14'(pix[15:11]) * 14'(gain);
      g_p = 15'(pix[10:5])  * 15'(gain);
      b_p = 14'(pix[4:0])   * 14'(gain);
      return {r_p[12:8], g_p[13:8], b_p[12:8]};
   endfunction

   logic [9:0]         dark_sum;
   logic [18:0]        shade_prod;
   logic [12:0]        pool_prod;
   logic [9:0]         shade_ff;
   logic [3:0]         pool_ff;
   logic [15:0]        pix0_ff, pix1_ff;
   logic signed [10:0] gain_diff;
   logic [8:0]         gain_clamped;
   logic [15:0]        lit0_ff, lit1_ff;
   logic [8:0]         gain_ff;

   assign dark_sum   = {2'b00, ~prof_a} + {2'b00, ~prof_b} + {2'b00, ~prof_d};
   assign shade_prod = 19'(dark_sum) * 19'(row_depth);
   assign pool_prod  = {5'd0, ~prof_pool} * 13'(POOL_DEPTH_K);

   always_ff @(posedge clock) begin
      if (ctl.load_mix) begin
         shade_ff <= shade_prod[18:9];
         pool_ff  <= pool_prod[12:9];
         pix0_ff  <= pixel_0;
         pix1_ff  <= pixel_1;
      end
   end

   assign gain_diff = $signed({2'b00, base_gain}) - $signed({1'b0, shade_ff})
                    - $signed({7'd0, pool_ff});

   always_comb begin
      priority if (gain_diff < 11'sd0) begin
         gain_clamped = 9'd0;
      end else if (gain_diff > 11'sd256) begin
         gain_clamped = 9'd256;
      end else begin
         gain_clamped = gain_diff[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         lit0_ff <= scale_pixel(pix0_ff, gain_clamped);
         lit1_ff <= scale_pixel(pix1_ff, gain_clamped);
         gain_ff <= gain_clamped;
      end
   end

   assign lit_pixel_0 = lit0_ff;
   assign lit_pixel_1 = lit1_ff;
   assign light_gain  = gain_ff;

endmodule

// ----- sim/tb_caustic_light_pixel_modulator.sv -----
`timescale 1ns / 1ps
// testbench for caustic_light_pixel_modulator: directed plan, then random rows of pixel pairs
// depends on clpm_pkg and the rtl top level; checks every result against a local light model or a planned value

module tb_caustic_light_pixel_modulator;

   localparam int PROFILE_ENTRIES = 512;
   localparam int SPAN_PIXELS     = 8;
   localparam int POOL_SHADE_K    = 30;
   localparam int LIMIT_CYCLES    = 600000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int PHASE_ITEMS     = 250;

   localparam logic [63:0] Q30_ONE         = 64'd1073741824;
   localparam logic [63:0] RIGHT_ANGLE_Q30 = 64'd1686629713;
   localparam logic [31:0] WAVE_B_OFFSET   = 32'd751921801;
   localparam logic [31:0] WAVE_D_OFFSET   = 32'd1640556661;

   // pool index 128 sits on the crest of the pool sine, so the pool term is zero
   localparam logic [31:0] POOL_CREST = 32'h0080_0000;

   localparam logic KIND_ROW_START = 1'b0;
   localparam logic KIND_PAIR      = 1'b1;

   typedef enum int {
      REG_BASE_GAIN = 0,
      REG_AMP_SCALE = 1,
      REG_POOL_STEP = 2
   } csr_reg_type;

   typedef enum int {
      PLAN_ITEM,
      PLAN_CSR
   } plan_kind_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] pix0;
      logic [15:0] pix1;
      logic [31:0] ph_a;
      logic [31:0] ph_b;
      logic [31:0] ph_d;
      logic [31:0] st_a;
      logic [31:0] st_b;
      logic [31:0] st_d;
      logic [31:0] pool_ph;
      logic [7:0]  amp;
   } req_type;

   typedef struct packed {
      logic [15:0] lit0;
      logic [15:0] lit1;
      logic [8:0]  gain;
   } light_type;

   typedef struct {
      plan_kind_type what;
      csr_reg_type   reg_sel;
      logic [31:0]   reg_val;
      req_type       item;
      bit            typed;
      light_type     want;
   } plan_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_kind;
   logic [15:0]                      req_pixel_0;
   logic [15:0]                      req_pixel_1;
   logic signed [31:0]               req_phase_a;
   logic signed [31:0]               req_phase_b;
   logic signed [31:0]               req_phase_d;
   logic signed [31:0]               req_step_a;
   logic signed [31:0]               req_step_b;
   logic signed [31:0]               req_step_d;
   logic signed [31:0]               req_pool_phase;
   logic [7:0]                       req_row_amplitude;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [15:0]                      rsp_lit_pixel_0;
   logic [15:0]                      rsp_lit_pixel_1;
   logic [8:0]                       rsp_light_gain;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [clpm_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [31:0]                      csr_pwdata;
   logic [31:0]                      csr_prdata;
   logic                             csr_pready;

   // light model state
   logic [7:0]  caustic_rom [PROFILE_ENTRIES];
   logic [7:0]  pool_rom [PROFILE_ENTRIES];
   logic [31:0] phase_acc [3];
   logic [31:0] phase_inc [3];
   logic [31:0] pool_acc;
   logic [8:0]  depth_now;
   int          span_pos;
   logic [8:0]  reg_base;
   logic [8:0]  reg_amp;
   logic [30:0] reg_pool_step;

   light_type pending_light [$];

   bit req_idle_en;
   bit rsp_idle_en;
   int cycle_count = 0;
   int error_count;
   int rows_sent;
   int pairs_sent;
   int lights_checked;
   int csr_writes;

   caustic_light_pixel_modulator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_pixel_0       (req_pixel_0),
      .req_pixel_1       (req_pixel_1),
      .req_phase_a       (req_phase_a),
      .req_phase_b       (req_phase_b),
      .req_phase_d       (req_phase_d),
      .req_step_a        (req_step_a),
      .req_step_b        (req_step_b),
      .req_step_d        (req_step_d),
      .req_pool_phase    (req_pool_phase),
      .req_row_amplitude (req_row_amplitude),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lit_pixel_0   (rsp_lit_pixel_0),
      .rsp_lit_pixel_1   (rsp_lit_pixel_1),
      .rsp_light_gain    (rsp_light_gain),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_light.size());
         $display("simulation failed");
         $finish;
      end
   end

   // sine of an angle in 2^-32 turns, q30, odd taylor series folded per quadrant
   function automatic logic signed [63:0] turn_sine(input logic [31:0] ang);
      logic [63:0] frac;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] poly;
      logic [63:0] mag;
      int          divs [5];
      divs = '{110, 72, 42, 20, 6};
      frac = {34'd0, ang[29:0]};
      if (ang[30]) begin
         frac = Q30_ONE - frac;
      end
      x    = (frac * RIGHT_ANGLE_Q30) >> 30;
      x2   = (x * x) >> 30;
      poly = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
         poly = Q30_ONE - (((x2 * poly) >> 30) / 64'(divs[i]));
      end
      mag = (x * poly) >> 30;
      if (ang[31]) begin
         return -$signed(mag);
      end
      return $signed(mag);
   endfunction

   function automatic logic [63:0] q30_power(input logic [63:0] base_v, input int n);
      logic [63:0] acc;
      acc = Q30_ONE;
      for (int i = 0; i < n; i++) begin
         acc = (acc * base_v) >> 30;
      end
      return acc;
   endfunction

   // bright side: (k/127)^5 <= v^11, dark side: (k/44.45)^5 <= w^8
   function automatic logic [7:0] shape_level(input logic signed [63:0] v);
      logic [63:0] bound;
      logic [63:0] kq;
      int          k;
      if (v == 64'sd0) begin
         return 8'd128;
      end
      if (v > 64'sd0) begin
         bound = q30_power(v, 11);
         for (k = 127; k > 0; k--) begin
            kq = (64'(k) << 30) / 64'd127;
            if (q30_power(kq, 5) <= bound) begin
               break;
            end
         end
         return 8'(128 + k);
      end
      bound = q30_power(-v, 8);
      for (k = 60; k > 0; k--) begin
         kq = (64'(k * 20) << 30) / 64'd889;
         if (q30_power(kq, 5) <= bound) begin
            break;
         end
      end
      return 8'(128 - k);
   endfunction

   function automatic logic [15:0] shade(input logic [15:0] c, input int g);
      int r;
      int gr;
      int b;
      r  = (int'(c[15:11]) * g) >> 8;
      gr = (int'(c[10:5]) * g) >> 8;
      b  = (int'(c[4:0]) * g) >> 8;
      return {r[4:0], gr[5:0], b[4:0]};
   endfunction

   task automatic model_step(input req_type r, output bit lit, output light_type res);
      int sum;
      int pool_v;
      int g;
      lit = 1'b0;
      res = '0;
      if (r.kind == KIND_ROW_START) begin
         phase_acc[0] = r.ph_a;
         phase_acc[1] = r.ph_b;
         phase_acc[2] = r.ph_d;
         phase_inc[0] = r.st_a;
         phase_inc[1] = r.st_b;
         phase_inc[2] = r.st_d;
         pool_acc     = r.pool_ph;
         depth_now    = 9'((int'(r.amp) * int'(reg_amp)) >> 8);
         span_pos     = 0;
      end else begin
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            sum += 255 - int'(caustic_rom[(phase_acc[i] >> 16) % PROFILE_ENTRIES]);
            phase_acc[i] = phase_acc[i] + phase_inc[i] + phase_inc[i];
         end
         pool_v = ((255 - int'(pool_rom[(pool_acc >> 16) % PROFILE_ENTRIES])) * POOL_SHADE_K)
                  >> 9;
         span_pos += 2;
         if (span_pos >= SPAN_PIXELS) begin
            span_pos -= SPAN_PIXELS;
            pool_acc = pool_acc + {1'b0, reg_pool_step} * 32'(SPAN_PIXELS);
         end
         g = int'(reg_base) - ((sum * int'(depth_now)) >> 9) - pool_v;
         if (g < 0) begin
            g = 0;
         end
         if (g > 256) begin
            g = 256;
         end
         lit      = 1'b1;
         res.lit0 = shade(r.pix0, g);
         res.lit1 = shade(r.pix1, g);
         res.gain = 9'(g);
      end
   endtask

   function automatic req_type rand_request(input logic kind);
      req_type r;
      r.kind    = kind;
      r.pix0    = 16'($urandom);
      r.pix1    = 16'($urandom);
      r.ph_a    = $urandom;
      r.ph_b    = $urandom;
      r.ph_d    = $urandom;
      r.pool_ph = $urandom;
      // mostly slow waves that walk the profiles, sometimes wild steps
      if ($urandom_range(0, 3) == 0) begin
         r.st_a = $urandom;
         r.st_b = $urandom;
         r.st_d = $urandom;
      end else begin
         r.st_a = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         r.st_b = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         r.st_d = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      end
      case ($urandom_range(0, 7))
         0: r.amp = 8'd0;
         1: r.amp = 8'd255;
         default: r.amp = 8'($urandom);
      endcase
      return r;
   endfunction

   function automatic plan_row_type plan_row(input logic [31:0] pa, pb, pd, sa, sb, sd, pp,
                                             input logic [7:0] amp);
      plan_row_type p;
      p              = '{what: PLAN_ITEM, reg_sel: REG_BASE_GAIN, default: '0};
      p.what         = PLAN_ITEM;
      p.item.kind    = KIND_ROW_START;
      p.item.ph_a    = pa;
      p.item.ph_b    = pb;
      p.item.ph_d    = pd;
      p.item.st_a    = sa;
      p.item.st_b    = sb;
      p.item.st_d    = sd;
      p.item.pool_ph = pp;
      p.item.amp     = amp;
      return p;
   endfunction

   function automatic plan_row_type plan_pair(input logic [15:0] p0, p1);
      plan_row_type p;
      p           = '{what: PLAN_ITEM, reg_sel: REG_BASE_GAIN, default: '0};
      p.what      = PLAN_ITEM;
      p.item.kind = KIND_PAIR;
      p.item.pix0 = p0;
      p.item.pix1 = p1;
      return p;
   endfunction

   function automatic plan_row_type plan_pair_lit(input logic [15:0] p0, p1, e0, e1,
                                                  input logic [8:0] eg);
      plan_row_type p;
      p       = plan_pair(p0, p1);
      p.typed = 1'b1;
      p.want  = '{lit0: e0, lit1: e1, gain: eg};
      return p;
   endfunction

   function automatic plan_row_type plan_csr(input csr_reg_type sel, input logic [31:0] val);
      plan_row_type p;
      p         = '{what: PLAN_CSR, reg_sel: REG_BASE_GAIN, default: '0};
      p.what    = PLAN_CSR;
      p.reg_sel = sel;
      p.reg_val = val;
      return p;
   endfunction

   task automatic push_request(input req_type r, input bit typed = 1'b0,
                               input light_type want = '0);
      int        gap;
      bit        lit;
      light_type res;
      gap = req_idle_en ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= r.kind;
      req_pixel_0       <= r.pix0;
      req_pixel_1       <= r.pix1;
      req_phase_a       <= r.ph_a;
      req_phase_b       <= r.ph_b;
      req_phase_d       <= r.ph_d;
      req_step_a        <= r.st_a;
      req_step_b        <= r.st_b;
      req_step_d        <= r.st_d;
      req_pool_phase    <= r.pool_ph;
      req_row_amplitude <= r.amp;
      do @(posedge clock); while (req_stall);
      model_step(r, lit, res);
      if (lit) begin
         pending_light.push_back(typed ? want : res);
         pairs_sent++;
      end else begin
         rows_sent++;
      end
   endtask

   // hold the request side until every pending pair is back and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_light.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type sel, input logic [31:0] val);
      logic [31:0] stored;
      case (sel)
         REG_BASE_GAIN: stored = val & 32'h0000_01FF;
         REG_AMP_SCALE: stored = val & 32'h0000_01FF;
         default:       stored = val & 32'h7FFF_FFFF;
      endcase
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= clpm_pkg::CSR_ADDR_W'(4 * int'(sel));
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (sel)
         REG_BASE_GAIN: reg_base = stored[8:0];
         REG_AMP_SCALE: reg_amp = stored[8:0];
         default:       reg_pool_step = stored[30:0];
      endcase
      csr_writes++;
      // read back the same register
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (csr_prdata !== stored) begin
         error_count++;
         if (error_count <= 10) begin
            $display("csr readback of register %s: expected %h, got %h", sel.name(), stored,
                     csr_prdata);
         end
      end
   endtask

   // result side: random stall per transaction, compare against the oldest pending light
   initial begin
      int        hold;
      light_type want;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         hold = rsp_idle_en ? $urandom_range(0, 19) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (pending_light.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("unexpected result at cycle %0d: %h %h gain %0d", cycle_count,
                        rsp_lit_pixel_0, rsp_lit_pixel_1, rsp_light_gain);
            end
         end else begin
            want = pending_light.pop_front();
            lights_checked++;
            if (rsp_lit_pixel_0 !== want.lit0 || rsp_lit_pixel_1 !== want.lit1 ||
                rsp_light_gain !== want.gain) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("result %0d mismatch: expected %h %h gain %0d, got %h %h gain %0d",
                           lights_checked, want.lit0, want.lit1, want.gain,
                           rsp_lit_pixel_0, rsp_lit_pixel_1, rsp_light_gain);
               end
            end
         end
      end
   end

   initial begin
      plan_row_type plan [$];
      logic [63:0] wide;
      logic [31:0] t1;
      logic [31:0] t2;
      logic [31:0] t3;
      logic signed [63:0] s1;
      logic signed [63:0] mix;
      int          n_phase;
      int          k;
      int          mode;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_kind          = KIND_PAIR;
      req_pixel_0       = '0;
      req_pixel_1       = '0;
      req_phase_a       = '0;
      req_phase_b       = '0;
      req_phase_d       = '0;
      req_step_a        = '0;
      req_step_b        = '0;
      req_step_d        = '0;
      req_pool_phase    = '0;
      req_row_amplitude = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      error_count       = 0;
      rows_sent         = 0;
      pairs_sent        = 0;
      lights_checked    = 0;
      csr_writes        = 0;
      req_idle_en       = 1'b1;
      rsp_idle_en       = 1'b1;

      reg_base      = 9'd256;
      reg_amp       = 9'd256;
      reg_pool_step = 31'd69424;
      for (int i = 0; i < 3; i++) begin
         phase_acc[i] = '0;
         phase_inc[i] = '0;
      end
      pool_acc  = '0;
      depth_now = '0;
      span_pos  = 0;

      for (int i = 0; i < PROFILE_ENTRIES; i++) begin
         wide = 64'(i);
         t1   = 32'((wide << 32) / 64'(PROFILE_ENTRIES));
         wide = 64'(23 * i);
         t2   = 32'((wide << 32) / 64'(10 * PROFILE_ENTRIES)) + WAVE_B_OFFSET;
         wide = 64'(37 * i);
         t3   = 32'((wide << 32) / 64'(10 * PROFILE_ENTRIES)) + WAVE_D_OFFSET;
         s1   = turn_sine(t1);
         mix  = (64'sd60 * s1 + 64'sd30 * turn_sine(t2) + 64'sd18 * turn_sine(t3)) / 64'sd100;
         caustic_rom[i] = shape_level(mix);
         pool_rom[i]    = 8'(64'sd128 + (s1 * 64'sd126) / 64'sd1073741824);
      end

      // pairs before any row start run on the cleared accumulators
      plan.push_back(plan_pair(16'hFFFF, 16'hFFFF));
      plan.push_back(plan_pair(16'h0000, 16'h0000));
      plan.push_back(plan_row(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'h0001_0000, 32'h8000_0000, 8'hFF));
      plan.push_back(plan_pair(16'hF800, 16'h07E0));
      plan.push_back(plan_pair(16'h001F, 16'hFFFF));
      plan.push_back(plan_pair(16'hAAAA, 16'h5555));
      plan.push_back(plan_pair(16'h5555, 16'hAAAA));
      plan.push_back(plan_pair(16'hFFFF, 16'h0001));
      // zero depth on the pool crest: unity gain
      plan.push_back(plan_row(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000,
                              32'h0000_8000, POOL_CREST, 8'h00));
      plan.push_back(plan_pair_lit(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 9'd256));
      plan.push_back(plan_pair_lit(16'h1234, 16'hFEDC, 16'h1234, 16'hFEDC, 9'd256));
      // black frame clamps to zero gain
      plan.push_back(plan_csr(REG_BASE_GAIN, 32'd0));
      plan.push_back(plan_pair_lit(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 9'd0));
      plan.push_back(plan_row(32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3C3C_3C3C, 32'h0003_0000,
                              32'hFFFD_0000, 32'h0000_0001, 32'h4000_0000, 8'hFF));
      plan.push_back(plan_pair_lit(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 9'd0));
      // base gain above unity clamps to 256
      plan.push_back(plan_csr(REG_BASE_GAIN, 32'd511));
      plan.push_back(plan_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, POOL_CREST, 8'h00));
      plan.push_back(plan_pair_lit(16'hF81F, 16'h07E0, 16'hF81F, 16'h07E0, 9'd256));
      plan.push_back(plan_csr(REG_BASE_GAIN, 32'd256));
      plan.push_back(plan_csr(REG_AMP_SCALE, 32'd334));
      plan.push_back(plan_csr(REG_POOL_STEP, 32'h7FFF_FFFF));
      plan.push_back(plan_row(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0002_0000,
                              32'h0005_0000, 32'hFFF9_0000, 32'hFFFF_FFFF, 8'hFF));
      plan.push_back(plan_pair(16'hFFFF, 16'hFFFF));
      plan.push_back(plan_pair(16'h0000, 16'hFFFF));
      plan.push_back(plan_pair(16'h8410, 16'h7BEF));
      plan.push_back(plan_pair(16'hFFFF, 16'hFFFF));
      plan.push_back(plan_pair(16'hC618, 16'h39E7));
      plan.push_back(plan_csr(REG_POOL_STEP, 32'd0));
      plan.push_back(plan_csr(REG_AMP_SCALE, 32'd256));
      plan.push_back(plan_row(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h0000_4000,
                              32'hFFFF_C000, 32'h0001_8000, 32'h7654_3210, 8'h80));
      plan.push_back(plan_pair(16'h7FFF, 16'hFFFE));
      plan.push_back(plan_pair(16'h0821, 16'hF7DE));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].what == PLAN_CSR) begin
            drain_results();
            csr_write(plan[i].reg_sel, plan[i].reg_val);
         end else begin
            push_request(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      // random rows under several register settings
      for (int p = 0; p < 5; p++) begin
         drain_results();
         case (p)
            0: begin
               csr_write(REG_BASE_GAIN, 32'd256);
               csr_write(REG_AMP_SCALE, 32'd256);
               csr_write(REG_POOL_STEP, 32'd69424);
            end
            1: begin
               csr_write(REG_BASE_GAIN, $urandom_range(0, 256));
               csr_write(REG_AMP_SCALE, 32'd334);
               csr_write(REG_POOL_STEP, 32'h7FFF_FFFF);
            end
            2: begin
               csr_write(REG_BASE_GAIN, 32'd511);
               csr_write(REG_AMP_SCALE, $urandom_range(256, 334));
               csr_write(REG_POOL_STEP, 32'd0);
            end
            3: begin
               csr_write(REG_BASE_GAIN, $urandom_range(128, 256));
               csr_write(REG_AMP_SCALE, $urandom_range(256, 334));
               csr_write(REG_POOL_STEP, $urandom & 32'h7FFF_FFFF);
            end
            default: begin
               csr_write(REG_BASE_GAIN, 32'd256);
               csr_write(REG_AMP_SCALE, 32'd334);
               csr_write(REG_POOL_STEP, $urandom_range(0, 32'h0010_0000));
            end
         endcase
         n_phase = 0;
         while (n_phase < PHASE_ITEMS) begin
            mode        = $urandom_range(0, 3);
            req_idle_en = mode[0];
            rsp_idle_en = mode[1];
            if ($urandom_range(0, 19) == 0) begin
               drain_results();
            end
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 16);
            // now and then the pairs just run on past the end of the previous row
            if ($urandom_range(0, 15) != 0) begin
               push_request(rand_request(KIND_ROW_START));
               n_phase++;
            end
            for (int j = 0; j < k; j++) begin
               push_request(rand_request(KIND_PAIR));
               n_phase++;
            end
         end
      end

      drain_results();
      error_count += pending_light.size();
      $display("%0d row starts and %0d pixel pairs sent, %0d results checked", rows_sent,
               pairs_sent, lights_checked);
      $display("%0d register writes, each read back; %0d failures", csr_writes, error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
